### hdl/spcc_pkg.sv
// Package: shared types, codes and constants of the supercap pulse-charge controller.
`timescale 1ns / 1ps
package spcc_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_FAST     = 2'd1,
        FUNC_NORMAL   = 2'd2,
        FUNC_TASK_END = 2'd3
    } func_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_IVL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_IVL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_MV    = 3'd4;

    localparam logic [15:0] FAST_IVL_RST   = 16'd500;
    localparam logic [15:0] NORMAL_IVL_RST = 16'd1500;
    localparam logic [15:0] HOLDOFF_RST    = 16'd100;
    localparam logic [12:0] FULL_MV_RST    = 13'd4900;
    localparam logic [12:0] LOSS_MV_RST    = 13'd3600;

    localparam logic [12:0] MV_PER_FS      = 13'd6200;   // full-scale millivolts
    localparam logic [12:0] DONE_MV        = 13'd5000;
    localparam logic [12:0] SHORT_PERIOD_MV = 13'd3600;
    localparam logic [12:0] LONG_PULSE_MV  = 13'd3000;
    localparam logic [3:0]  FULL_HOLD_CNT  = 4'd10;
    localparam logic [5:0]  PULSE_LONG_MS  = 6'd50;
    localparam logic [5:0]  PULSE_SHORT_MS = 6'd10;
    localparam logic [6:0]  PCT_MAX        = 7'd100;

    // floor(v/50) for v < 8192 as (v * 20972) >> 20
    localparam logic [14:0] PCT_RECIP      = 15'd20972;
    localparam int          PCT_SHIFT      = 20;

    // ADC code to millivolts: floor(code*6200/4096)
    function automatic logic [12:0] code_to_mv(input logic [11:0] code);
        logic [24:0] prod;
        prod = {13'd0, code} * {12'd0, MV_PER_FS};
        return prod[24:12];
    endfunction

    function automatic logic [6:0] mv_to_pct(input logic [12:0] mv);
        logic [27:0] prod;
        logic [7:0]  q;
        prod = {15'd0, mv} * {13'd0, PCT_RECIP};
        q    = prod[PCT_SHIFT+7:PCT_SHIFT];
        return (q > {1'b0, PCT_MAX}) ? PCT_MAX : q[6:0];
    endfunction

endpackage

### hdl/spcc_if.sv
// Interfaces: input and result channels of the supercap pulse-charge controller.
`timescale 1ns / 1ps
interface spcc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        others_idle;
    logic        link_busy;
    logic [11:0] adc_code;

    modport source (output valid, func, others_idle, link_busy, adc_code, input ready);
    modport sink   (input valid, func, others_idle, link_busy, adc_code, output ready);
endinterface

interface spcc_out_if;
    logic        valid;
    logic        ready;
    logic        charge_pulse;
    logic [5:0]  pulse_ms;
    logic        sampled;
    logic [12:0] voltage_mv;
    logic [6:0]  charge_percent;
    logic        supply_from_cap;
    logic        charging_flag;
    logic        fast_mode;
    logic        fast_done;

    modport source (output valid, charge_pulse, pulse_ms, sampled, voltage_mv, charge_percent,
                    supply_from_cap, charging_flag, fast_mode, fast_done, input ready);
    modport sink   (input valid, charge_pulse, pulse_ms, sampled, voltage_mv, charge_percent,
                    supply_from_cap, charging_flag, fast_mode, fast_done, output ready);
endinterface

### hdl/supercap_pulse_charge_controller_top.sv
// Top level: supercap pulse-charge controller, one result beat per input beat.
`timescale 1ns / 1ps
// Each input beat (tick, fast mode, normal mode, task finished) is processed in the
// cycle it is accepted: the controller state updates at that edge and one result beat
// lands in the output register the same edge, and a new beat is taken every cycle as long
// as the result side keeps draining (ready stays high whenever the output register is
// empty or being drained; a result held by a stalled sink holds off the input until it
// leaves). The path per beat is the ADC-to-millivolt constant multiply plus a few
// compares and counter updates; the millivolt-to-percent conversion sits after the
// last-sample state register. The supply selects the module after reset. Write the
// configuration registers only while no result is outstanding.
module supercap_pulse_charge_controller_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [spcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spcc_pkg::CFG_DATA_W-1:0] cfg_data,
    spcc_in_if.sink                        in_ch,
    spcc_out_if.source                     out_ch
);
    import spcc_pkg::*;

    // configuration registers
    logic [15:0] fast_ivl_reg;
    logic [15:0] normal_ivl_reg;
    logic [15:0] holdoff_rl_reg;
    logic [12:0] full_mv_reg;
    logic [12:0] loss_mv_reg;

    // controller state
    logic [1:0]  period_count_reg, period_count_next;
    logic [1:0]  period_limit_reg, period_limit_next;
    logic [15:0] holdoff_reg,      holdoff_next;
    logic [15:0] sample_count_reg, sample_count_next;
    logic        collect_reg,      collect_next;
    logic        mode_fast_reg,    mode_fast_next;
    logic        long_pulse_reg,   long_pulse_next;
    logic [3:0]  full_hold_reg,    full_hold_next;
    logic [12:0] last_mv_reg,      last_mv_next;
    logic        rising_reg,       rising_next;
    logic        cap_supply_reg,   cap_supply_next;

    // output register
    logic        out_valid_reg;
    logic        o_pulse_reg,   o_pulse_next;
    logic [5:0]  o_ms_reg,      o_ms_next;
    logic        o_sampled_reg, o_sampled_next;
    logic        o_done_reg,    o_done_next;

    logic        accept;
    func_t       func;
    logic [12:0] sample_mv;
    logic [15:0] ivl;
    logic [3:0]  full_hold_inc;

    // Take a new beat whenever the output register is free or being drained.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign func        = func_t'(in_ch.func);
    assign sample_mv   = code_to_mv(in_ch.adc_code);
    assign ivl         = (in_ch.link_busy || mode_fast_reg) ? fast_ivl_reg : normal_ivl_reg;
    assign full_hold_inc = full_hold_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_ivl_reg   <= FAST_IVL_RST;
            normal_ivl_reg <= NORMAL_IVL_RST;
            holdoff_rl_reg <= HOLDOFF_RST;
            full_mv_reg    <= FULL_MV_RST;
            loss_mv_reg    <= LOSS_MV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FAST_IVL:   fast_ivl_reg   <= cfg_data;
                CFG_NORMAL_IVL: normal_ivl_reg <= cfg_data;
                CFG_HOLDOFF:    holdoff_rl_reg <= cfg_data;
                CFG_FULL_MV:    full_mv_reg    <= cfg_data[12:0];
                CFG_LOSS_MV:    loss_mv_reg    <= cfg_data[12:0];
                default:        ;   // unknown index: drop the write
            endcase
        end
    end

    always_comb
    begin
        period_count_next = period_count_reg;
        period_limit_next = period_limit_reg;
        holdoff_next      = holdoff_reg;
        sample_count_next = sample_count_reg;
        collect_next      = collect_reg;
        mode_fast_next    = mode_fast_reg;
        long_pulse_next   = long_pulse_reg;
        full_hold_next    = full_hold_reg;
        last_mv_next      = last_mv_reg;
        rising_next       = rising_reg;
        cap_supply_next   = cap_supply_reg;
        o_pulse_next      = 1'b0;
        o_ms_next         = 6'd0;
        o_sampled_next    = 1'b0;
        o_done_next       = 1'b0;

        unique case (func)
            FUNC_FAST:     mode_fast_next = 1'b1;
            FUNC_NORMAL:   mode_fast_next = 1'b0;
            FUNC_TASK_END: holdoff_next   = holdoff_rl_reg;
            FUNC_TICK:
            begin
                // charge period and hold-off
                period_count_next = period_count_reg + 2'd1;
                if (holdoff_reg != 16'd0)
                    holdoff_next = holdoff_reg - 16'd1;
                if (period_count_next >= period_limit_reg)
                begin
                    period_count_next = 2'd0;
                    if (in_ch.others_idle && holdoff_next == 16'd0)
                    begin
                        o_pulse_next = 1'b1;
                        if (mode_fast_reg)
                            o_ms_next = long_pulse_reg ? PULSE_LONG_MS : PULSE_SHORT_MS;
                    end
                end

                // sampling: count the interval, then take the sample on the next tick
                if (!collect_reg)
                begin
                    sample_count_next = sample_count_reg + 16'd1;
                    if (sample_count_next >= ivl)
                    begin
                        sample_count_next = 16'd0;
                        collect_next      = 1'b1;
                    end
                end
                else
                begin
                    collect_next   = 1'b0;
                    o_sampled_next = 1'b1;
                    last_mv_next   = sample_mv;
                    rising_next    = mode_fast_reg &&
                                     (sample_mv > last_mv_reg || sample_mv == 13'd0);
                    // loss check last: it wins when both thresholds are met
                    if (sample_mv >= full_mv_reg)
                        cap_supply_next = 1'b1;
                    if (sample_mv <= loss_mv_reg)
                        cap_supply_next = 1'b0;
                    if (mode_fast_reg && sample_mv >= DONE_MV)
                    begin
                        full_hold_next = full_hold_inc;
                        if (full_hold_inc >= FULL_HOLD_CNT)
                        begin
                            full_hold_next = 4'd0;
                            mode_fast_next = 1'b0;
                            rising_next    = 1'b0;
                            o_done_next    = 1'b1;
                        end
                    end
                    if (mode_fast_next)
                        period_limit_next = 2'd1;
                    else
                        period_limit_next = (sample_mv >= SHORT_PERIOD_MV) ? 2'd1 : 2'd2;
                    long_pulse_next = (sample_mv > LONG_PULSE_MV);
                end
            end
            default: ;
        endcase
    end

    // Advance the state only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg <= 2'd0;
            period_limit_reg <= 2'd2;
            holdoff_reg      <= HOLDOFF_RST;
            sample_count_reg <= 16'd0;
            collect_reg      <= 1'b0;
            mode_fast_reg    <= 1'b0;
            long_pulse_reg   <= 1'b0;
            full_hold_reg    <= 4'd0;
            last_mv_reg      <= 13'd0;
            rising_reg       <= 1'b0;
            cap_supply_reg   <= 1'b0;
        end
        else if (accept)
        begin
            period_count_reg <= period_count_next;
            period_limit_reg <= period_limit_next;
            holdoff_reg      <= holdoff_next;
            sample_count_reg <= sample_count_next;
            collect_reg      <= collect_next;
            mode_fast_reg    <= mode_fast_next;
            long_pulse_reg   <= long_pulse_next;
            full_hold_reg    <= full_hold_next;
            last_mv_reg      <= last_mv_next;
            rising_reg       <= rising_next;
            cap_supply_reg   <= cap_supply_next;
        end
    end

    // Output register: load on accept, hold while the sink stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            o_pulse_reg   <= o_pulse_next;
            o_ms_reg      <= o_ms_next;
            o_sampled_reg <= o_sampled_next;
            o_done_reg    <= o_done_next;
        end
    end

    // The state registers hold exactly the after-item values until the next beat,
    // and no beat is taken while a result waits unless it drains at the same edge.
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.charge_pulse    = o_pulse_reg;
    assign out_ch.pulse_ms        = o_ms_reg;
    assign out_ch.sampled         = o_sampled_reg;
    assign out_ch.fast_done       = o_done_reg;
    assign out_ch.voltage_mv      = last_mv_reg;
    assign out_ch.charge_percent  = mv_to_pct(last_mv_reg);
    assign out_ch.supply_from_cap = cap_supply_reg;
    assign out_ch.charging_flag   = rising_reg;
    assign out_ch.fast_mode       = mode_fast_reg;

endmodule

### tb/tb_supercap_pulse_charge_controller_top.sv
// Testbench: supercap pulse-charge controller, checked beat by beat against a predictor.
`timescale 1ns / 1ps
module tb_supercap_pulse_charge_controller_top;
    import spcc_pkg::*;

    // Clock, reset and run limits
    localparam realtime CLK_PERIOD  = 10.0;
    localparam int      RESET_CYCLES = 10;
    localparam int      DRAIN_PAD    = 4;     // padding after the last readout is in
    localparam int      QUIET_LIMIT  = 2000;  // cycles with no beat on either channel
    localparam int      BURST_CYCLES = 300;   // long receiver hold-off
    localparam int      GAP_PCT      = 19;    // idle percentage on each side

    // Index that decodes to no register: a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // One input beat as the sender sees it.
    typedef struct packed {
        func_t       func;
        logic        others_idle;
        logic        link_busy;
        logic [11:0] adc_code;
    } ctrl_beat_t;

    // One result beat: the controller readout after that input beat.
    typedef struct packed {
        logic        charge_pulse;
        logic [5:0]  pulse_ms;
        logic        sampled;
        logic [12:0] voltage_mv;
        logic [6:0]  charge_percent;
        logic        supply_from_cap;
        logic        charging_flag;
        logic        fast_mode;
        logic        fast_done;
    } readout_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    spcc_in_if  in_ch ();
    spcc_out_if out_ch ();

    supercap_pulse_charge_controller_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the controller: registers and state, advanced once per
    // accepted input beat. Every beat yields exactly one readout, which
    // is queued here until the result channel delivers it.
    // ------------------------------------------------------------------
    logic [15:0] fast_ivl_r, normal_ivl_r, holdoff_reload_r;
    logic [12:0] full_mv_r, loss_mv_r;

    logic [1:0]  period_cnt, period_lim;
    logic [15:0] holdoff_cnt, sample_cnt;
    logic        collect_armed, fast_on, long_pulse_on, rising, on_cap;
    logic [3:0]  full_hits;
    logic [12:0] last_mv;

    readout_t    due_readouts[$];

    // Run statistics for the closing summary
    int beats_sent, readouts_checked, mismatches;
    int pulses_due, samples_due, fast_done_due, config_sets;

    // Side controls shared with the receiver process
    bit src_gaps  = 1'b1;
    bit sink_gaps = 1'b1;
    bit stall_burst_req = 1'b0;

    function automatic void reset_shadow();
        fast_ivl_r       = FAST_IVL_RST;
        normal_ivl_r     = NORMAL_IVL_RST;
        holdoff_reload_r = HOLDOFF_RST;
        full_mv_r        = FULL_MV_RST;
        loss_mv_r        = LOSS_MV_RST;
        period_cnt       = 2'd0;
        period_lim       = 2'd2;
        holdoff_cnt      = HOLDOFF_RST;
        sample_cnt       = 16'd0;
        collect_armed    = 1'b0;
        fast_on          = 1'b0;
        long_pulse_on    = 1'b0;
        full_hits        = 4'd0;
        last_mv          = 13'd0;
        rising           = 1'b0;
        on_cap           = 1'b0;
    endfunction

    // Mirror a register write; registers keep only their low bits.
    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FAST_IVL:   fast_ivl_r       = data;
            CFG_NORMAL_IVL: normal_ivl_r     = data;
            CFG_HOLDOFF:    holdoff_reload_r = data;
            CFG_FULL_MV:    full_mv_r        = data[12:0];
            CFG_LOSS_MV:    loss_mv_r        = data[12:0];
            default: ;
        endcase
    endfunction

    // Advance the shadow by one accepted beat and queue the readout it causes.
    function automatic void advance_charger(input ctrl_beat_t b);
        readout_t    r;
        logic [15:0] ivl;
        logic [12:0] mv;
        logic [12:0] prev_mv;
        int          pct;
        r = '0;
        case (b.func)
            FUNC_FAST:     fast_on = 1'b1;
            FUNC_NORMAL:   fast_on = 1'b0;
            FUNC_TASK_END: holdoff_cnt = holdoff_reload_r;
            default: begin
                // Charge period and hold-off
                period_cnt = period_cnt + 2'd1;
                if (holdoff_cnt != 16'd0)
                    holdoff_cnt = holdoff_cnt - 16'd1;
                if (period_cnt >= period_lim) begin
                    period_cnt = 2'd0;
                    if (b.others_idle && holdoff_cnt == 16'd0) begin
                        r.charge_pulse = 1'b1;
                        if (fast_on)
                            r.pulse_ms = long_pulse_on ? PULSE_LONG_MS : PULSE_SHORT_MS;
                    end
                end
                // Sampling: count to the interval and arm, then sample on the next tick
                if (!collect_armed) begin
                    ivl = (b.link_busy || fast_on) ? fast_ivl_r : normal_ivl_r;
                    sample_cnt = sample_cnt + 16'd1;
                    if (sample_cnt >= ivl) begin
                        sample_cnt    = 16'd0;
                        collect_armed = 1'b1;
                    end
                end else begin
                    collect_armed = 1'b0;
                    r.sampled     = 1'b1;
                    prev_mv       = last_mv;
                    mv            = 13'((int'(b.adc_code) * int'(MV_PER_FS)) / 4096);
                    last_mv       = mv;
                    rising        = fast_on && (mv > prev_mv || mv == 13'd0);
                    // Loss check last: it wins when both thresholds hold
                    if (mv >= full_mv_r)
                        on_cap = 1'b1;
                    if (mv <= loss_mv_r)
                        on_cap = 1'b0;
                    // Full-charge count clears only on reaching ten
                    if (fast_on && mv >= DONE_MV) begin
                        full_hits = full_hits + 4'd1;
                        if (full_hits >= FULL_HOLD_CNT) begin
                            full_hits   = 4'd0;
                            fast_on     = 1'b0;
                            rising      = 1'b0;
                            r.fast_done = 1'b1;
                        end
                    end
                    if (fast_on)
                        period_lim = 2'd1;
                    else
                        period_lim = (mv >= SHORT_PERIOD_MV) ? 2'd1 : 2'd2;
                    long_pulse_on = (mv > LONG_PULSE_MV);
                end
            end
        endcase
        pct = int'(last_mv) / 50;
        if (pct > int'(PCT_MAX))
            pct = int'(PCT_MAX);
        r.voltage_mv      = last_mv;
        r.charge_percent  = 7'(pct);
        r.supply_from_cap = on_cap;
        r.charging_flag   = rising;
        r.fast_mode       = fast_on;
        pulses_due    += int'(r.charge_pulse);
        samples_due   += int'(r.sampled);
        fast_done_due += int'(r.fast_done);
        due_readouts.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Result checking: compare each delivered readout with the oldest one due.
    // ------------------------------------------------------------------
    readout_t got_r, want_r;

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got_r.charge_pulse    = out_ch.charge_pulse;
            got_r.pulse_ms        = out_ch.pulse_ms;
            got_r.sampled         = out_ch.sampled;
            got_r.voltage_mv      = out_ch.voltage_mv;
            got_r.charge_percent  = out_ch.charge_percent;
            got_r.supply_from_cap = out_ch.supply_from_cap;
            got_r.charging_flag   = out_ch.charging_flag;
            got_r.fast_mode       = out_ch.fast_mode;
            got_r.fast_done       = out_ch.fast_done;
            if (due_readouts.size() == 0) begin
                $error("result beat with no readout due");
                mismatches++;
            end else begin
                want_r = due_readouts.pop_front();
                check_field("charge_pulse", 16'(want_r.charge_pulse),
                            16'(got_r.charge_pulse));
                check_field("pulse_ms", 16'(want_r.pulse_ms), 16'(got_r.pulse_ms));
                check_field("sampled", 16'(want_r.sampled), 16'(got_r.sampled));
                check_field("voltage_mv", 16'(want_r.voltage_mv), 16'(got_r.voltage_mv));
                check_field("charge_percent", 16'(want_r.charge_percent),
                            16'(got_r.charge_percent));
                check_field("supply_from_cap", 16'(want_r.supply_from_cap),
                            16'(got_r.supply_from_cap));
                check_field("charging_flag", 16'(want_r.charging_flag),
                            16'(got_r.charging_flag));
                check_field("fast_mode", 16'(want_r.fast_mode), 16'(got_r.fast_mode));
                check_field("fast_done", 16'(want_r.fast_done), 16'(got_r.fast_done));
                readouts_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drive ready at each falling edge. A burst request holds
    // ready low for a long stretch counted here, so the block backs up.
    // ------------------------------------------------------------------
    initial begin : receiver
        int burst_left;
        burst_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_burst_req) begin
                stall_burst_req = 1'b0;
                burst_left      = BURST_CYCLES;
            end
            if (burst_left > 0) begin
                burst_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(sink_gaps && $urandom_range(0, 99) < GAP_PCT);
            end
        end
    end

    // Watchdog: end the run when neither channel moves a beat for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one beat from the falling edge; hold it until accepted, then predict.
    task automatic send_beat(input ctrl_beat_t b);
        @(negedge clk);
        while (src_gaps && $urandom_range(0, 99) < GAP_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= b.func;
        in_ch.others_idle <= b.others_idle;
        in_ch.link_busy   <= b.link_busy;
        in_ch.adc_code    <= b.adc_code;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        advance_charger(b);
        beats_sent++;
    endtask

    // Drop valid and wait until every readout is in, so registers can change.
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (due_readouts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        shadow_write(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic [15:0] fast_ivl, input logic [15:0] normal_ivl,
                                input logic [15:0] holdoff, input logic [15:0] full_mv,
                                input logic [15:0] loss_mv);
        settle();
        write_reg(CFG_FAST_IVL,   fast_ivl);
        write_reg(CFG_NORMAL_IVL, normal_ivl);
        write_reg(CFG_HOLDOFF,    holdoff);
        write_reg(CFG_FULL_MV,    full_mv);
        write_reg(CFG_LOSS_MV,    loss_mv);
        config_sets++;
    endtask

    function automatic ctrl_beat_t make_beat(input func_t f, input logic idle,
                                             input logic busy, input logic [11:0] code);
        ctrl_beat_t b;
        b.func        = f;
        b.others_idle = idle;
        b.link_busy   = busy;
        b.adc_code    = code;
        return b;
    endfunction

    // ADC code: extremes, the 5000 mV edge, a high-charge band when asked, else anything.
    function automatic logic [11:0] pick_code(input bit charge_bias);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 12'd0;
        if (r < 16)
            return 12'hFFF;
        if (charge_bias && r < 60)
            return 12'($urandom_range(3304, 4095));
        if (r < 68)
            return 12'($urandom_range(3290, 3320));
        return 12'($urandom());
    endfunction

    // Random beat; percentages pick the non-tick operations, the rest are ticks.
    function automatic ctrl_beat_t rand_beat(input int p_fast, input int p_norm,
                                             input int p_end, input bit charge_bias);
        ctrl_beat_t b;
        int         r;
        r = $urandom_range(0, 99);
        if (r < p_fast)
            b.func = FUNC_FAST;
        else if (r < p_fast + p_norm)
            b.func = FUNC_NORMAL;
        else if (r < p_fast + p_norm + p_end)
            b.func = FUNC_TASK_END;
        else
            b.func = FUNC_TICK;
        b.others_idle = ($urandom_range(0, 99) < 75);
        b.link_busy   = ($urandom_range(0, 99) < 30);
        b.adc_code    = pick_code(charge_bias);
        return b;
    endfunction

    task automatic run_phase(input int n, input int p_fast, input int p_norm,
                             input int p_end, input bit charge_bias);
        repeat (n) send_beat(rand_beat(p_fast, p_norm, p_end, charge_bias));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset readout, every operation, code extremes, zero fast interval,
    // pulse widths in both modes, the sample landing after a mode change.
    task automatic test_directed_corners();
        // Reset values: hold-off still running, no pulse yet
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'd0));
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b1, 12'hFFF));
        apply_config(16'd0, 16'd1, 16'd0, 16'd4900, 16'd3600);
        send_beat(make_beat(FUNC_TASK_END, 1'b0, 1'b0, 12'd0));    // hold-off cleared
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'd0));        // arm the sample
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'hFFF));      // full scale, pulse
        send_beat(make_beat(FUNC_FAST, 1'b0, 1'b0, 12'd0));
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b1, 12'hFFF));      // long pulse
        send_beat(make_beat(FUNC_TICK, 1'b0, 1'b0, 12'hFFF));      // busy tasks: no pulse
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'd0));
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b1, 12'd0));        // zero reads as rising
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'd2048));     // short pulse
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'd2048));
        send_beat(make_beat(FUNC_NORMAL, 1'b1, 1'b1, 12'hFFF));
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b1, 12'd3303));     // link busy arms
        send_beat(make_beat(FUNC_FAST, 1'b1, 1'b1, 12'hFFF));
        send_beat(make_beat(FUNC_TICK, 1'b0, 1'b0, 12'd3304));     // sample in fast mode
        send_beat(make_beat(FUNC_TASK_END, 1'b1, 1'b1, 12'hFFF));
    endtask

    // Full threshold below loss threshold: the loss side must win.
    task automatic test_threshold_overlap();
        apply_config(16'd0, 16'd0, 16'd3, 16'd1000, 16'd5000);
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'd0));
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'd2000));     // both met
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'd0));
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'hFFF));      // full only
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'd0));
        send_beat(make_beat(FUNC_TICK, 1'b1, 1'b0, 12'd661));      // right at full
    endtask

    // Fast charging to completion: short intervals, high codes, few mode exits.
    task automatic test_fast_charge_runs();
        apply_config(16'd1, 16'd3, 16'd0, 16'd4900, 16'd3600);
        run_phase(250, 4, 1, 3, 1'b1);
        apply_config(16'd2, 16'd5, 16'd3, 16'd4500, 16'd3000);
        run_phase(250, 4, 1, 3, 1'b1);
        apply_config(16'd0, 16'd1, 16'd1, 16'd5500, 16'd2000);
        run_phase(250, 4, 2, 4, 1'b1);
    endtask

    // Register extremes, plus a write to an index that decodes to nothing.
    task automatic test_register_extremes();
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd6199, 16'd0);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        run_phase(150, 5, 5, 10, 1'b0);
        apply_config(16'd1, 16'd1, 16'd0, 16'd0, 16'd6199);
        write_reg(CFG_UNUSED_IDX, 16'h0000);
        run_phase(150, 5, 5, 5, 1'b1);
    endtask

    // Long receiver hold-off while the sender keeps offering, then a
    // stretch with no idling on either side.
    task automatic test_backpressure();
        apply_config(16'd1, 16'd2, 16'd1, 16'd4900, 16'd3600);
        @(posedge clk);
        stall_burst_req = 1'b1;
        run_phase(150, 4, 2, 4, 1'b1);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        run_phase(150, 4, 2, 4, 1'b1);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // Random small intervals and thresholds anywhere in range.
    task automatic test_random_configs();
        repeat (4) begin
            apply_config(16'($urandom_range(1, 12)), 16'($urandom_range(1, 40)),
                         16'($urandom_range(0, 20)), 16'($urandom_range(0, 6199)),
                         16'($urandom_range(0, 6199)));
            run_phase(125, 5, 3, 6, 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_FAST_IVL;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.func        = FUNC_TICK;
        in_ch.others_idle = 1'b0;
        in_ch.link_busy   = 1'b0;
        in_ch.adc_code    = '0;
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_threshold_overlap();
        test_fast_charge_runs();
        test_register_extremes();
        test_backpressure();
        test_random_configs();

        // Drain; the watchdog bounds this wait.
        settle();

        $display("Run covered %0d input beats over %0d register settings; %0d readouts checked.",
                 beats_sent, config_sets, readouts_checked);
        $display("Predicted %0d voltage samples, %0d charge pulses, %0d fast-charge completions.",
                 samples_due, pulses_due, fast_done_due);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
